// ===== src/mgd_pkg.sv =====
`default_nettype none

package mgd_pkg;

   localparam int SEED_W = 16;

   typedef logic [1:0] dir_type;

   localparam dir_type DIR_N = 2'd0;
   localparam dir_type DIR_S = 2'd1;
   localparam dir_type DIR_E = 2'd2;
   localparam dir_type DIR_W = 2'd3;

   // entry k is the k-th direction tried from a cell
   typedef dir_type [3:0] order_type;

   localparam order_type ORDER_BASE = {DIR_W, DIR_E, DIR_S, DIR_N};

   typedef struct packed {
      logic      busy;
      order_type order;
   } shuf_status_type;

endpackage

`default_nettype wire

// ===== src/mgd_shuffle.sv =====
`default_nettype none

module mgd_shuffle (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        seed_load,
   input  wire logic [mgd_pkg::SEED_W-1:0]  seed_value,
   input  wire logic                        start,
   output mgd_pkg::shuf_status_type         status
);

   localparam logic [mgd_pkg::SEED_W-1:0] LFSR_TAPS = 16'hB400;
   localparam logic [mgd_pkg::SEED_W-1:0] LFSR_ONE  = 16'h0001;

   logic [mgd_pkg::SEED_W-1:0] lfsr_ff, lfsr_in;
   logic                       busy_ff, busy_in;
   logic [1:0]                 idx_ff, idx_in;
   mgd_pkg::order_type         order_ff, order_in;
   logic [mgd_pkg::SEED_W-1:0] draw;
   logic [1:0]                 pick;

   // 4 = 1 mod 3, so base-4 digit sum keeps the residue
   function automatic logic [1:0] mod3(input logic [mgd_pkg::SEED_W-1:0] v);
      logic [4:0] s;
      logic [2:0] t;
      s = '0;
      for (int k = 0; k < mgd_pkg::SEED_W / 2; k++) begin
         s = s + 5'(v[2*k +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      if (t >= 3'd6) begin
         t = t - 3'd6;
      end else if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      return t[1:0];
   endfunction

   always_comb begin
      draw = {1'b0, lfsr_ff[mgd_pkg::SEED_W-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);

      unique case (idx_ff)
         2'd3: begin
            pick = draw[1:0];
         end
         2'd2: begin
            pick = mod3(draw);
         end
         default: begin
            pick = {1'b0, draw[0]};
         end
      endcase

      order_in = order_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      lfsr_in  = lfsr_ff;

      if (busy_ff) begin
         order_in[idx_ff] = order_ff[pick];
         order_in[pick]   = order_ff[idx_ff];
         idx_in           = idx_ff - 2'd1;
         busy_in          = (idx_ff != 2'd1);
         lfsr_in          = draw;
      end
      if (start) begin
         order_in = mgd_pkg::ORDER_BASE;
         idx_in   = 2'd3;
         busy_in  = 1'b1;
      end
      if (seed_load) begin
         lfsr_in = (seed_value == '0) ? LFSR_ONE : seed_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_ONE;
         busy_ff <= 1'b0;
      end else begin
         lfsr_ff <= lfsr_in;
         busy_ff <= busy_in;
      end
      idx_ff   <= idx_in;
      order_ff <= order_in;
   end

   assign status.busy  = busy_ff;
   assign status.order = order_ff;

endmodule

`default_nettype wire

// ===== src/maze_generator_dfs.sv =====
// Channel   Dir  Payload                                  Handshake
// req_      in   tuser: op; tdata: cell_x, cell_y         tvalid/tready
// rsp_      out  tuser: done_op; tdata: is_wall, cell_type tvalid/tready
// csr_      in   random_seed at byte address 0             APB, pready tied high
//
// Read: accept issues the registered cell RAM read, S_RDWAIT forms the result, S_RESULT loads it to rsp_.
// Generate: RAM clearing of all GRID_WIDTH*GRID_HEIGHT cells, one write a cycle,
// then for each carved cell: visit, 3 shuffle draws, one probe read per in-bounds
// direction, stack pop; the single cell RAM port sets the pace.
// One item in work at a time; a new item is taken while a result waits on rsp_.
// Reset clears control only; cells read as wall until the first generate.
`default_nettype none

module maze_generator_dfs #(
   parameter int GRID_WIDTH  = 32,
   parameter int GRID_HEIGHT = 32,
   parameter int STACK_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [4:0] cell_x, [9:5] cell_y
   input  wire logic [0:0]  req_tuser,   // [0] op

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] is_wall, [2:1] cell_type
   output logic [0:0]       rsp_tuser,   // [0] done_op

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int XW    = $clog2(GRID_WIDTH);
   localparam int YW    = $clog2(GRID_HEIGHT);
   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int SPW   = $clog2(STACK_DEPTH + 1);
   localparam int SIW   = $clog2(STACK_DEPTH);
   localparam int X_TOP = ((GRID_WIDTH - 2) % 2 != 0) ? GRID_WIDTH - 2 : GRID_WIDTH - 3;
   localparam int Y_TOP = ((GRID_HEIGHT - 2) % 2 != 0) ? GRID_HEIGHT - 2 : GRID_HEIGHT - 3;

   localparam logic [AW-1:0] ENT_ADDR  = AW'(1);
   localparam logic [AW-1:0] EXIT_ADDR = AW'((GRID_HEIGHT - 1) * GRID_WIDTH + GRID_WIDTH - 2);
   localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

   localparam logic       OP_GENERATE  = 1'b0;
   localparam logic       OP_READ      = 1'b1;
   localparam logic [1:0] CT_PLAIN     = 2'd0;
   localparam logic [1:0] CT_ENTRANCE  = 2'd1;
   localparam logic [1:0] CT_EXIT      = 2'd2;
   localparam logic       REG_SEED_IDX = 1'b0;

   // cell word: [1] wall, [0] visited
   localparam logic [1:0] CELL_WALL    = 2'b10;
   localparam logic [1:0] CELL_OPEN    = 2'b00;
   localparam logic [1:0] CELL_VISITED = 2'b01;

   localparam logic [mgd_pkg::SEED_W-1:0] SEED_RESET = 16'h0001;

   typedef struct packed {
      logic [XW-1:0]      x;
      logic [YW-1:0]      y;
      mgd_pkg::order_type order;
      logic [2:0]         next;
   } frame_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_VISIT,
      S_SHUF,
      S_STEP,
      S_PROBE,
      S_POP,
      S_RDWAIT,
      S_RESULT
   } state_type;

   state_type                  state_ff, state_in;
   logic [SPW-1:0]             sp_ff, sp_in;
   frame_type                  top_ff, top_in;
   logic [XW-1:0]              vx_ff, vx_in;
   logic [YW-1:0]              vy_ff, vy_in;
   logic [XW-1:0]              mx_ff, mx_in;
   logic [YW-1:0]              my_ff, my_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [4:0]                 rd_x_ff, rd_x_in;
   logic [4:0]                 rd_y_ff, rd_y_in;
   logic                       in_grid_ff, in_grid_in;
   logic                       generated_ff, generated_in;
   logic                       res_wall_ff, res_wall_in;
   logic [1:0]                 res_type_ff, res_type_in;
   logic                       res_op_ff, res_op_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_wall_ff, rsp_wall_in;
   logic [1:0]                 rsp_type_ff, rsp_type_in;
   logic                       rsp_op_ff, rsp_op_in;
   logic [mgd_pkg::SEED_W-1:0] seed_ff, seed_in;

   logic [1:0]                 cell_mem [CELLS];
   logic [1:0]                 cell_rd_ff;
   logic                       cell_we, cell_re;
   logic [AW-1:0]              cell_addr;
   logic [1:0]                 cell_wdata;

   frame_type                  stk_mem [STACK_DEPTH];
   frame_type                  stk_rd_ff;
   logic                       stk_we, stk_re;
   logic [SIW-1:0]             stk_waddr, stk_raddr;
   logic [SPW-1:0]             sp_m1, sp_m2;

   logic                       seed_wr;
   logic                       shuf_start;
   mgd_pkg::shuf_status_type   shuf_st;

   mgd_pkg::dir_type           dir;
   logic                       dir_ok;
   logic [XW-1:0]              nx, mxc;
   logic [YW-1:0]              ny, myc;

   function automatic logic [XW-1:0] clamp_x(input logic [4:0] v);
      logic [4:0] o;
      o = v | 5'd1;
      if (int'(o) > X_TOP) begin
         return XW'(X_TOP);
      end
      return XW'(o);
   endfunction

   function automatic logic [YW-1:0] clamp_y(input logic [4:0] v);
      logic [4:0] o;
      o = v | 5'd1;
      if (int'(o) > Y_TOP) begin
         return YW'(Y_TOP);
      end
      return YW'(o);
   endfunction

   mgd_shuffle u_shuffle (
      .clock      (clock),
      .reset      (reset),
      .seed_load  (seed_wr),
      .seed_value (csr_pwdata[mgd_pkg::SEED_W-1:0]),
      .start      (shuf_start),
      .status     (shuf_st)
   );

   // config port
   assign seed_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_SEED_IDX);
   assign seed_in    = seed_wr ? csr_pwdata[mgd_pkg::SEED_W-1:0] : seed_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_SEED_IDX) ? 32'(seed_ff) : '0;

   assign sp_m1 = sp_ff - SPW'(1);
   assign sp_m2 = sp_ff - SPW'(2);

   // neighbor two cells away and the wall cell between
   always_comb begin
      dir = top_ff.order[top_ff.next[1:0]];
      unique case (dir)
         mgd_pkg::DIR_N: begin
            dir_ok = int'(top_ff.y) >= 3;
            nx     = top_ff.x;
            ny     = top_ff.y - YW'(2);
            mxc    = top_ff.x;
            myc    = top_ff.y - YW'(1);
         end
         mgd_pkg::DIR_S: begin
            dir_ok = int'(top_ff.y) <= GRID_HEIGHT - 4;
            nx     = top_ff.x;
            ny     = top_ff.y + YW'(2);
            mxc    = top_ff.x;
            myc    = top_ff.y + YW'(1);
         end
         mgd_pkg::DIR_E: begin
            dir_ok = int'(top_ff.x) <= GRID_WIDTH - 4;
            nx     = top_ff.x + XW'(2);
            ny     = top_ff.y;
            mxc    = top_ff.x + XW'(1);
            myc    = top_ff.y;
         end
         mgd_pkg::DIR_W: begin
            dir_ok = int'(top_ff.x) >= 3;
            nx     = top_ff.x - XW'(2);
            ny     = top_ff.y;
            mxc    = top_ff.x - XW'(1);
            myc    = top_ff.y;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      top_in       = top_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      clr_in       = clr_ff;
      rd_x_in      = rd_x_ff;
      rd_y_in      = rd_y_ff;
      in_grid_in   = in_grid_ff;
      generated_in = generated_ff;
      res_wall_in  = res_wall_ff;
      res_type_in  = res_type_ff;
      res_op_in    = res_op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_wall_in  = rsp_wall_ff;
      rsp_type_in  = rsp_type_ff;
      rsp_op_in    = rsp_op_ff;

      cell_we    = 1'b0;
      cell_re    = 1'b0;
      cell_addr  = '0;
      cell_wdata = CELL_WALL;
      stk_we     = 1'b0;
      stk_re     = 1'b0;
      stk_waddr  = sp_m1[SIW-1:0];
      stk_raddr  = sp_m2[SIW-1:0];
      shuf_start = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == OP_READ) begin
                  rd_x_in    = req_tdata[4:0];
                  rd_y_in    = req_tdata[9:5];
                  in_grid_in = (int'(req_tdata[4:0]) < GRID_WIDTH)
                               && (int'(req_tdata[9:5]) < GRID_HEIGHT);
                  cell_re    = in_grid_in;
                  cell_addr  = AW'(int'(req_tdata[9:5]) * GRID_WIDTH
                                   + int'(req_tdata[4:0]));
                  state_in   = S_RDWAIT;
               end else begin
                  vx_in    = clamp_x(req_tdata[4:0]);
                  vy_in    = clamp_y(req_tdata[9:5]);
                  sp_in    = '0;
                  clr_in   = '0;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            cell_we    = 1'b1;
            cell_addr  = clr_ff;
            cell_wdata = (clr_ff == ENT_ADDR || clr_ff == EXIT_ADDR) ? CELL_OPEN : CELL_WALL;
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = S_VISIT;
            end
         end
         S_VISIT: begin
            cell_we     = 1'b1;
            cell_addr   = AW'(int'(vy_ff) * GRID_WIDTH + int'(vx_ff));
            cell_wdata  = CELL_VISITED;
            stk_we      = (sp_ff != '0);
            top_in.x    = vx_ff;
            top_in.y    = vy_ff;
            top_in.next = '0;
            sp_in       = sp_ff + SPW'(1);
            shuf_start  = 1'b1;
            state_in    = S_SHUF;
         end
         S_SHUF: begin
            if (!shuf_st.busy) begin
               top_in.order = shuf_st.order;
               state_in     = S_STEP;
            end
         end
         S_STEP: begin
            if (top_ff.next[2]) begin
               if (sp_ff == SPW'(1)) begin
                  sp_in        = '0;
                  generated_in = 1'b1;
                  res_wall_in  = 1'b0;
                  res_type_in  = CT_PLAIN;
                  res_op_in    = OP_GENERATE;
                  state_in     = S_RESULT;
               end else begin
                  stk_re   = 1'b1;
                  sp_in    = sp_m1;
                  state_in = S_POP;
               end
            end else begin
               top_in.next = top_ff.next + 3'd1;
               if (dir_ok && sp_ff != SPW'(STACK_DEPTH)) begin
                  vx_in     = nx;
                  vy_in     = ny;
                  mx_in     = mxc;
                  my_in     = myc;
                  cell_re   = 1'b1;
                  cell_addr = AW'(int'(ny) * GRID_WIDTH + int'(nx));
                  state_in  = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (!cell_rd_ff[0]) begin
               cell_we    = 1'b1;
               cell_addr  = AW'(int'(my_ff) * GRID_WIDTH + int'(mx_ff));
               cell_wdata = CELL_OPEN;
               state_in   = S_VISIT;
            end else begin
               state_in = S_STEP;
            end
         end
         S_POP: begin
            top_in   = stk_rd_ff;
            state_in = S_STEP;
         end
         S_RDWAIT: begin
            res_wall_in = (in_grid_ff && generated_ff) ? cell_rd_ff[1] : 1'b1;
            res_type_in = CT_PLAIN;
            if (generated_ff && rd_x_ff == 5'd1 && rd_y_ff == 5'd0) begin
               res_type_in = CT_ENTRANCE;
            end else if (generated_ff && int'(rd_x_ff) == GRID_WIDTH - 2
                         && int'(rd_y_ff) == GRID_HEIGHT - 1) begin
               res_type_in = CT_EXIT;
            end
            res_op_in = OP_READ;
            state_in  = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_wall_in  = res_wall_ff;
               rsp_type_in  = res_type_ff;
               rsp_op_in    = res_op_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         generated_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= SEED_RESET;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         generated_ff <= generated_in;
         rsp_valid_ff <= rsp_valid_in;
         seed_ff      <= seed_in;
      end
      top_ff      <= top_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      clr_ff      <= clr_in;
      rd_x_ff     <= rd_x_in;
      rd_y_ff     <= rd_y_in;
      in_grid_ff  <= in_grid_in;
      res_wall_ff <= res_wall_in;
      res_type_ff <= res_type_in;
      res_op_ff   <= res_op_in;
      rsp_wall_ff <= rsp_wall_in;
      rsp_type_ff <= rsp_type_in;
      rsp_op_ff   <= rsp_op_in;
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_addr] <= cell_wdata;
      end
      if (cell_re) begin
         cell_rd_ff <= cell_mem[cell_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= top_ff;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_type_ff, rsp_wall_ff};
   assign rsp_tuser  = rsp_op_ff;

   a_visit_pushes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VISIT) |=> (sp_ff == $past(sp_ff) + SPW'(1)))
      else $error("visit did not push a frame");

   a_step_has_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (sp_ff != '0))
      else $error("walk step with empty stack");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while busy");

   a_shuffle_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHUF && !shuf_st.busy) |=> (state_ff == S_STEP))
      else $error("shuffle result not taken");

endmodule

`default_nettype wire

// ===== tb/sv/maze_generator_dfs_tb.sv =====
`default_nettype none

module maze_generator_dfs_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mgd_pkg::*;

   localparam int GRID_W       = 32;
   localparam int GRID_H       = 32;
   localparam int STACK_DEPTH  = 256;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_ITEMS  = 45;

   localparam logic OP_GENERATE = 1'b0;
   localparam logic OP_READ     = 1'b1;

   localparam logic [1:0] CELL_PLAIN    = 2'd0;
   localparam logic [1:0] CELL_ENTRANCE = 2'd1;
   localparam logic [1:0] CELL_EXIT     = 2'd2;

   localparam int         REG_SEED    = 0;
   localparam logic [2:0] ADDR_SEED   = 3'd0;
   localparam logic [2:0] ADDR_UNUSED = 3'd4;

   typedef struct {
      logic       is_wall;
      logic [1:0] cell_type;
      logic       done_op;
   } cell_result_t;

   typedef struct {
      int        x;
      int        y;
      order_type order;
      int        next;
   } walk_frame_t;

   class maze_tracker;
      bit           wall_map [GRID_W*GRID_H];
      bit           seen_map [GRID_W*GRID_H];
      walk_frame_t  walk [$];
      logic [15:0]  lfsr;
      bit           carved;
      cell_result_t awaited [$];
      int           errors;

      function new();
         lfsr = 16'd1;
         carved = 1'b0;
         errors = 0;
         foreach (wall_map[i]) begin
            wall_map[i] = 1'b1;
            seen_map[i] = 1'b0;
         end
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= REPORT_LIMIT) $display("%s", msg);
      endfunction

      function void load_seed(int index, logic [31:0] value);
         if (index == REG_SEED) lfsr = (value[15:0] == 16'd0) ? 16'd1 : value[15:0];
      endfunction

      function logic [15:0] next_draw();
         lfsr = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? 16'hB400 : 16'h0000);
         return lfsr;
      endfunction

      function int odd_clamp(int v, int size);
         int top;
         top = ((size - 2) % 2 != 0) ? size - 2 : size - 3;
         if (v % 2 == 0) v++;
         return (v > top) ? top : v;
      endfunction

      function void visit(int x, int y);
         walk_frame_t f;
         int          i;
         int          j;
         dir_type     t;
         seen_map[y*GRID_W + x] = 1'b1;
         wall_map[y*GRID_W + x] = 1'b0;
         f.x = x;
         f.y = y;
         f.order = ORDER_BASE;
         f.next = 0;
         // Fisher-Yates over the four directions
         for (i = 3; i > 0; i--) begin
            j = int'(next_draw() % (i + 1));
            t = f.order[i];
            f.order[i] = f.order[j];
            f.order[j] = t;
         end
         walk.push_back(f);
      endfunction

      function void carve(int sx, int sy);
         int      top;
         int      dx;
         int      dy;
         int      nx;
         int      ny;
         dir_type d;
         foreach (wall_map[i]) begin
            wall_map[i] = 1'b1;
            seen_map[i] = 1'b0;
         end
         wall_map[1] = 1'b0;
         wall_map[(GRID_H - 1)*GRID_W + GRID_W - 2] = 1'b0;
         carved = 1'b1;
         walk.delete();
         visit(sx, sy);
         while (walk.size() > 0) begin
            top = walk.size() - 1;
            if (walk[top].next >= 4) begin
               void'(walk.pop_back());
            end else begin
               d = walk[top].order[walk[top].next];
               walk[top].next = walk[top].next + 1;
               case (d)
                  DIR_N: begin dx = 0;  dy = -2; end
                  DIR_S: begin dx = 0;  dy = 2;  end
                  DIR_E: begin dx = 2;  dy = 0;  end
                  default: begin dx = -2; dy = 0; end
               endcase
               nx = walk[top].x + dx;
               ny = walk[top].y + dy;
               if (nx > 0 && nx < GRID_W - 1 && ny > 0 && ny < GRID_H - 1
                   && !seen_map[ny*GRID_W + nx] && walk.size() < STACK_DEPTH) begin
                  wall_map[(walk[top].y + dy/2)*GRID_W + walk[top].x + dx/2] = 1'b0;
                  visit(nx, ny);
               end
            end
         end
      endfunction

      function void note_request(logic op, logic [4:0] cx, logic [4:0] cy);
         cell_result_t r;
         int           x;
         int           y;
         x = cx;
         y = cy;
         if (op == OP_GENERATE) begin
            x = odd_clamp(x, GRID_W);
            y = odd_clamp(y, GRID_H);
            carve(x, y);
         end
         r.done_op = op;
         r.cell_type = CELL_PLAIN;
         if (x >= GRID_W || y >= GRID_H) begin
            r.is_wall = 1'b1;
         end else begin
            r.is_wall = wall_map[y*GRID_W + x];
            if (carved) begin
               if (x == 1 && y == 0) r.cell_type = CELL_ENTRANCE;
               else if (x == GRID_W - 2 && y == GRID_H - 1) r.cell_type = CELL_EXIT;
            end
         end
         awaited.push_back(r);
      endfunction

      function void check_result(logic is_wall, logic [1:0] cell_type, logic done_op);
         cell_result_t e;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected item: is_wall=%0b cell_type=%0d done_op=%0b",
                             is_wall, cell_type, done_op));
            return;
         end
         e = awaited.pop_front();
         if (is_wall !== e.is_wall)
            report($sformatf("is_wall mismatch: expected %0b got %0b", e.is_wall, is_wall));
         if (cell_type !== e.cell_type)
            report($sformatf("cell_type mismatch: expected %0d got %0d",
                             e.cell_type, cell_type));
         if (done_op !== e.done_op)
            report($sformatf("done_op mismatch: expected %0b got %0b", e.done_op, done_op));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [4:0] cell_x, [9:5] cell_y
   logic [0:0]  req_tuser;   // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [0] is_wall, [2:1] cell_type
   logic [0:0]  rsp_tuser;   // [0] done_op
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   maze_tracker maze = new();

   bit hold_request = 1'b0;
   int burst_left = 0;
   int idle_cycles = 0;

   maze_generator_dfs #(
      .GRID_WIDTH(GRID_W),
      .GRID_HEIGHT(GRID_H),
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            maze.check_result(rsp_tdata[0], rsp_tdata[2:1], rsp_tuser[0]);
         if (req_tvalid && req_tready)
            maze.note_request(req_tuser[0], req_tdata[4:0], req_tdata[9:5]);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            maze.load_seed(csr_paddr >> 2, csr_pwdata);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: own stall pattern, plus a long hold-off on request
   initial begin
      int stall_mode;
      int mode_left;
      int stall_count;
      stall_mode = 0;
      mode_left = 0;
      stall_count = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         stall_count++;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 9) < 6);
            default: rsp_tready <= (stall_count % 5 != 0);
         endcase
      end
   end

   task automatic send_item(input logic op, input logic [4:0] x, input logic [4:0] y);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'd0, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (maze.awaited.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [15:0] seed, input bit under_pressure);
      int         k;
      int         pick;
      logic       op;
      logic [4:0] x;
      logic [4:0] y;
      write_csr(ADDR_SEED, {16'($urandom), seed});
      if (under_pressure) hold_request = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
         if (under_pressure) op = OP_READ;
         else if (k == 0) op = OP_GENERATE;
         else op = ($urandom_range(0, 99) < 8) ? OP_GENERATE : OP_READ;
         x = $urandom_range(0, 31);
         y = $urandom_range(0, 31);
         pick = $urandom_range(0, 19);
         if (op == OP_READ && pick == 0) begin
            x = 5'd1;
            y = 5'd0;
         end else if (op == OP_READ && pick == 1) begin
            x = 5'(GRID_W - 2);
            y = 5'(GRID_H - 1);
         end
         send_item(op, x, y);
      end
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing generated yet: all wall, no entrance or exit
      send_item(OP_READ, 5'd0, 5'd0);
      send_item(OP_READ, 5'd1, 5'd0);
      send_item(OP_READ, 5'd30, 5'd31);
      send_item(OP_READ, 5'd31, 5'd31);
      wait_idle();

      // zero seed, even start rounded up
      write_csr(ADDR_SEED, 32'h0000_0000);
      send_item(OP_GENERATE, 5'd0, 5'd0);
      send_item(OP_READ, 5'd1, 5'd0);
      send_item(OP_READ, 5'd30, 5'd31);
      send_item(OP_READ, 5'd0, 5'd0);
      send_item(OP_READ, 5'd31, 5'd31);
      send_item(OP_READ, 5'd1, 5'd1);
      send_item(OP_READ, 5'd2, 5'd1);
      wait_idle();

      // unused register index, then max seed and clamped start
      write_csr(ADDR_UNUSED, 32'h0000_5A5A);
      write_csr(ADDR_SEED, 32'h0000_FFFF);
      send_item(OP_GENERATE, 5'd31, 5'd31);
      send_item(OP_READ, 5'd29, 5'd29);
      send_item(OP_READ, 5'd21, 5'd10);
      send_item(OP_READ, 5'd10, 5'd21);
      send_item(OP_READ, 5'd31, 5'd0);
      send_item(OP_READ, 5'd0, 5'd31);
      wait_idle();

      // upper write bits ignored; back-to-back generates carry the lfsr on
      write_csr(ADDR_SEED, 32'hABCD_0001);
      send_item(OP_GENERATE, 5'd30, 5'd2);
      send_item(OP_GENERATE, 5'd2, 5'd30);
      send_item(OP_READ, 5'd1, 5'd0);
      send_item(OP_READ, 5'd30, 5'd31);
      send_item(OP_READ, 5'd3, 5'd29);
      wait_idle();

      run_phase(16'($urandom_range(1, 65535)), 1'b0);
      run_phase(16'd1, 1'b0);
      run_phase(16'($urandom_range(2, 65534)), 1'b1);
      run_phase(16'd0, 1'b0);
      run_phase(16'hFFFF, 1'b0);
      run_phase(16'($urandom_range(1, 65535)), 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (maze.awaited.size() != 0)
         maze.report($sformatf("%0d results never arrived", maze.awaited.size()));
      if (maze.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/mgd_pkg.sv
src/mgd_shuffle.sv
src/maze_generator_dfs.sv
tb/sv/maze_generator_dfs_tb.sv
